// ===== hdl/dtr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtr_pkg
// Shared types, constants and the counter load function of the divider timer
// with delayed reload.
// ----------------------------------------------------------------------------
`default_nettype none

package dtr_pkg;

	localparam int CounterBits = 14;

	localparam logic [15:0] AddrDiv  = 16'hFF04;
	localparam logic [15:0] AddrTima = 16'hFF05;
	localparam logic [15:0] AddrTma  = 16'hFF06;
	localparam logic [15:0] AddrTac  = 16'hFF07;

	localparam int DivShift = 6;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_NORMAL    = 2'd0,
		PH_SCHEDULED = 2'd1,
		PH_RELOADING = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CounterBits-1:0] cycle_counter;
		logic [7:0]             count_reg;
		logic [7:0]             reload_reg;
		logic [7:0]             control_reg;
		logic                   prev_tap;
		phase_t                 phase;
	} state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_request;
		logic       bad_address;
	} result_t;

	// loads the cycle counter and samples the gated tap for a falling edge
	function automatic state_t load_counter(input state_t s_in,
			input logic [CounterBits-1:0] value);
		state_t s;
		logic   tap;
		s = s_in;
		s.cycle_counter = value;
		case (s.control_reg[1:0])
			2'd0: tap = value[7];
			2'd1: tap = value[1];
			2'd2: tap = value[3];
			default: tap = value[5];
		endcase
		tap = tap & s.control_reg[2];
		if (!tap && s.prev_tap) begin
			s.count_reg = s.count_reg + 8'd1;
			if (s.count_reg == 8'd0) begin
				s.phase = PH_SCHEDULED;
			end
		end
		s.prev_tap = tap;
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/dtr_step.sv =====
// ----------------------------------------------------------------------------
// dtr_step
// Next state and result of the timer for one tick, read or write word.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_step (
	input  wire dtr_pkg::state_t  state_cur,
	input  wire logic [1:0]       command,
	input  wire logic [15:0]      address,
	input  wire logic [7:0]       write_data,
	output dtr_pkg::state_t       state_nxt,
	output dtr_pkg::result_t      result
);

	logic [dtr_pkg::CounterBits+7:0] div_ext;
	logic                            addr_ok;

	assign div_ext = {8'd0, state_cur.cycle_counter};
	assign addr_ok = (address == dtr_pkg::AddrDiv) || (address == dtr_pkg::AddrTima) ||
		(address == dtr_pkg::AddrTma) || (address == dtr_pkg::AddrTac);

	always_comb begin
		dtr_pkg::state_t s;
		s = state_cur;
		case (command)
			dtr_pkg::CMD_TICK: begin
				if (s.phase == dtr_pkg::PH_SCHEDULED) begin
					s.phase = dtr_pkg::PH_RELOADING;
					s.count_reg = s.reload_reg;
				end else begin
					s.phase = dtr_pkg::PH_NORMAL;
				end
				s = dtr_pkg::load_counter(s,
					s.cycle_counter + {{(dtr_pkg::CounterBits-1){1'b0}}, 1'b1});
			end
			dtr_pkg::CMD_WRITE: begin
				case (address)
					dtr_pkg::AddrDiv: begin
						s = dtr_pkg::load_counter(s, '0);
					end
					dtr_pkg::AddrTima: begin
						if (s.phase == dtr_pkg::PH_SCHEDULED) begin
							s.count_reg = write_data;
							s.phase = dtr_pkg::PH_NORMAL;
						end else if (s.phase != dtr_pkg::PH_RELOADING) begin
							s.count_reg = write_data;
						end
					end
					dtr_pkg::AddrTma: begin
						s.reload_reg = write_data;
						if (s.phase == dtr_pkg::PH_RELOADING) begin
							s.count_reg = write_data;
						end
					end
					dtr_pkg::AddrTac: begin
						s.control_reg = write_data;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
		state_nxt = s;
	end

	always_comb begin
		result = '0;
		case (command)
			dtr_pkg::CMD_TICK: begin
				result.irq_request = (state_cur.phase == dtr_pkg::PH_SCHEDULED);
			end
			dtr_pkg::CMD_READ: begin
				case (address)
					dtr_pkg::AddrDiv:  result.read_data = div_ext[dtr_pkg::DivShift+7:dtr_pkg::DivShift];
					dtr_pkg::AddrTima: result.read_data = state_cur.count_reg;
					dtr_pkg::AddrTma:  result.read_data = state_cur.reload_reg;
					dtr_pkg::AddrTac:  result.read_data = state_cur.control_reg;
					default:           result.bad_address = 1'b1;
				endcase
			end
			dtr_pkg::CMD_WRITE: begin
				result.bad_address = !addr_ok;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/divider_timer_with_delayed_reload_core.sv =====
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload_core
// Timer with a free-running divider, counter, reload value and control byte,
// driven by one tick, register read or register write word per cycle when not stalled.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   command, address, write_data
//   out      from block out_valid/out_stall read_data, irq_request, bad_address
//
// A word goes to an input register, then through the step logic into the
// result register; one word per cycle is sustained while out does not stall.
// Timer state updates as a word moves from the input to the result register.
// arst_n clears all timer state and both valid flags.
// A stall at out holds the result register; in stalls only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_timer_with_delayed_reload_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             irq_request,
	output logic             bad_address
);

	logic             valid_s1;
	logic [1:0]       command_s1;
	logic [15:0]      address_s1;
	logic [7:0]       write_data_s1;
	logic             advance;
	logic             load_s1;
	dtr_pkg::state_t  state_q;
	dtr_pkg::state_t  state_nxt;
	dtr_pkg::result_t result_nxt;
	dtr_pkg::result_t result_q;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	dtr_step u_step (
		.state_cur  (state_q),
		.command    (command_s1),
		.address    (address_s1),
		.write_data (write_data_s1),
		.state_nxt  (state_nxt),
		.result     (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			command_s1    <= command;
			address_s1    <= address;
			write_data_s1 <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{cycle_counter: '0, count_reg: '0, reload_reg: '0,
				control_reg: '0, prev_tap: 1'b0, phase: dtr_pkg::PH_NORMAL};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign read_data   = result_q.read_data;
	assign irq_request = result_q.irq_request;
	assign bad_address = result_q.bad_address;

endmodule

`default_nettype wire

// ===== dv/dtr_timer_checker.sv =====
// ----------------------------------------------------------------------------
// dtr_timer_checker
// Watches both channels of the divider timer. Every accepted input word goes
// through a word-by-word model of the timer state. The model's answer is
// queued, and each accepted result word is compared field by field with the
// oldest queued answer. Counts of mismatches and of answers still owed go
// back to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_timer_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  read_data,
	input  wire logic        irq_request,
	input  wire logic        bad_address,
	output int               mismatch_count,
	output int               answers_owed,
	output int               answers_checked,
	output int               irq_seen,
	output int               bad_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [dtr_pkg::CounterBits-1:0] div_count;
	logic [7:0]                      tima;
	logic [7:0]                      tma;
	logic [7:0]                      tac;
	logic                            last_tap;
	dtr_pkg::phase_t                 phase;
	dtr_pkg::result_t                answers_due[$];

	function automatic void advance_divider(input logic [dtr_pkg::CounterBits-1:0] value);
		int unsigned bit_pos;
		logic        tap;
		div_count = value;
		bit_pos = (tac[1:0] == 2'd0) ? 7 : 2 * int'(tac[1:0]) - 1;
		tap = value[bit_pos] & tac[2];
		if (last_tap && !tap) begin
			tima = tima + 8'd1;
			if (tima == 8'd0) begin
				phase = dtr_pkg::PH_SCHEDULED;
			end
		end
		last_tap = tap;
	endfunction

	function automatic dtr_pkg::result_t timer_step(input logic [1:0] cmd,
			input logic [15:0] addr, input logic [7:0] data);
		dtr_pkg::result_t res;
		res = '0;
		case (cmd)
		dtr_pkg::CMD_TICK: begin
			if (phase == dtr_pkg::PH_SCHEDULED) begin
				phase = dtr_pkg::PH_RELOADING;
				tima = tma;
				res.irq_request = 1'b1;
			end else begin
				phase = dtr_pkg::PH_NORMAL;
			end
			advance_divider(div_count + 1'b1);
		end
		dtr_pkg::CMD_READ: begin
			case (addr)
			dtr_pkg::AddrDiv:  res.read_data = div_count[dtr_pkg::DivShift +: 8];
			dtr_pkg::AddrTima: res.read_data = tima;
			dtr_pkg::AddrTma:  res.read_data = tma;
			dtr_pkg::AddrTac:  res.read_data = tac;
			default:           res.bad_address = 1'b1;
			endcase
		end
		dtr_pkg::CMD_WRITE: begin
			case (addr)
			dtr_pkg::AddrDiv: advance_divider('0);
			dtr_pkg::AddrTima: begin
				if (phase == dtr_pkg::PH_SCHEDULED) begin
					tima = data;
					phase = dtr_pkg::PH_NORMAL;
				end else if (phase != dtr_pkg::PH_RELOADING) begin
					tima = data;
				end
			end
			dtr_pkg::AddrTma: begin
				tma = data;
				if (phase == dtr_pkg::PH_RELOADING) begin
					tima = data;
				end
			end
			dtr_pkg::AddrTac: tac = data;
			default: res.bad_address = 1'b1;
			endcase
		end
		default: begin
		end
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] seen,
			input logic [7:0] due);
		$display("%0t: %s mismatch on result word %0d: got 0x%02h, expected 0x%02h",
			$realtime, what, answers_checked, seen, due);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		dtr_pkg::result_t due;
		if (!arst_n) begin
			div_count = '0;
			tima = '0;
			tma = '0;
			tac = '0;
			last_tap = 1'b0;
			phase = dtr_pkg::PH_NORMAL;
			answers_due.delete();
			answers_owed = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch("unexpected", read_data, 8'h00);
				end else begin
					due = answers_due.pop_front();
					if (read_data !== due.read_data) begin
						report_mismatch("read_data", read_data, due.read_data);
					end
					if (irq_request !== due.irq_request) begin
						report_mismatch("irq_request", 8'(irq_request), 8'(due.irq_request));
					end
					if (bad_address !== due.bad_address) begin
						report_mismatch("bad_address", 8'(bad_address), 8'(due.bad_address));
					end
					irq_seen += int'(due.irq_request);
					bad_seen += int'(due.bad_address);
				end
				answers_checked++;
			end
			if (in_valid && !in_stall) begin
				answers_due.push_back(timer_step(command, address, write_data));
			end
			answers_owed = answers_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_divider_timer_with_delayed_reload_core.sv =====
// ----------------------------------------------------------------------------
// tb_divider_timer_with_delayed_reload_core
// Drives the divider timer with a short directed walk through overflow,
// reload and write override cases, then with random runs of ticks and
// register accesses around counter overflow, mixed with bus noise. Both
// channels idle at random. Checking is done by dtr_timer_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_divider_timer_with_delayed_reload_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam time        Period      = 20ns;
	localparam int         RandomWords = 600;
	localparam int         QuietLimit  = 1000;
	localparam logic [1:0] CmdUnused   = 2'd3;
	localparam logic [15:0] RegAddr [4] = '{dtr_pkg::AddrDiv, dtr_pkg::AddrTima,
		dtr_pkg::AddrTma, dtr_pkg::AddrTac};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        irq_request;
	logic        bad_address;

	int mismatch_count;
	int answers_owed;
	int answers_checked;
	int irq_seen;
	int bad_seen;
	int word_count;
	int ignored_count;
	int directed_count;
	int quiet_cycles;
	bit idle_on;

	always #(Period / 2) clk = ~clk;

	divider_timer_with_delayed_reload_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.address     (address),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.irq_request (irq_request),
		.bad_address (bad_address)
	);

	dtr_timer_checker timer_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.address         (address),
		.write_data      (write_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.read_data       (read_data),
		.irq_request     (irq_request),
		.bad_address     (bad_address),
		.mismatch_count  (mismatch_count),
		.answers_owed    (answers_owed),
		.answers_checked (answers_checked),
		.irq_seen        (irq_seen),
		.bad_seen        (bad_seen)
	);

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [7:0] data);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd;
		address <= addr;
		write_data <= data;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && !in_stall));
		@(negedge clk);
		if (cmd == dtr_pkg::CMD_TICK || (cmd != CmdUnused &&
				addr >= dtr_pkg::AddrDiv && addr <= dtr_pkg::AddrTac)) begin
			word_count++;
		end else begin
			ignored_count++;
		end
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		@(negedge clk);
		while (answers_owed != 0) @(negedge clk);
	endtask

	task automatic random_access();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'($urandom));
		end else if (pick < 6) begin
			send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTma, 8'($urandom));
		end else if (pick == 6) begin
			send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrDiv, 8'($urandom));
		end else if (pick == 7) begin
			send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTac, 8'($urandom));
		end else begin
			send_word(dtr_pkg::CMD_READ, RegAddr[$urandom_range(0, 3)], 8'($urandom));
		end
	endtask

	// counter preset close to wrap, then ticks with accesses sprinkled in
	task automatic overflow_run();
		int         pick;
		logic [1:0] tap;
		logic       enable;
		pick = $urandom_range(0, 9);
		tap = (pick < 5) ? 2'd1 : (pick < 8) ? 2'd2 : (pick == 8) ? 2'd3 : 2'd0;
		enable = ($urandom_range(0, 9) != 0);
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTac, {5'($urandom), enable, tap});
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTma,
			($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'($urandom_range(8'hF8, 8'hFF)));
		repeat ($urandom_range(8, 40)) begin
			if ($urandom_range(0, 3) == 0) begin
				random_access();
			end else begin
				send_word(dtr_pkg::CMD_TICK, 16'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic noise_run();
		logic [15:0] addr;
		repeat ($urandom_range(4, 12)) begin
			addr = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
				(16'hFF00 | 16'($urandom_range(0, 15)));
			send_word(2'($urandom_range(0, 3)), addr, 8'($urandom));
		end
	endtask

	initial begin : receive
		int hold;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = idle_on ? $urandom_range(0, 9) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("no word moved for %0d cycles, %0d answers owed", quiet_cycles,
				answers_owed);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = dtr_pkg::CMD_TICK;
		address = '0;
		write_data = '0;
		idle_on = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// bus edge cases
		send_word(dtr_pkg::CMD_READ, dtr_pkg::AddrDiv, 8'h00);
		send_word(dtr_pkg::CMD_READ, 16'h0000, 8'h00);
		send_word(dtr_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
		send_word(CmdUnused, 16'hFFFF, 8'hFF);
		// fast tap, counter one step from wrap
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTma, 8'hA5);
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTac, 8'h05);
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'hFF);
		repeat (4) send_word(dtr_pkg::CMD_TICK, 16'h0000, 8'h00);
		// counter write while reload is pending cancels it
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'h00);
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'hFF);
		repeat (5) send_word(dtr_pkg::CMD_TICK, 16'hFFFF, 8'hFF);
		// writes during the reload tick
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTma, 8'h3C);
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTima, 8'h11);
		send_word(dtr_pkg::CMD_READ, dtr_pkg::AddrTima, 8'h00);
		repeat (2) send_word(dtr_pkg::CMD_TICK, 16'h0000, 8'h00);
		// divider clear with the tap high gives a falling edge
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrDiv, 8'hFF);
		// tap change alone sends no pulse
		send_word(dtr_pkg::CMD_WRITE, dtr_pkg::AddrTac, 8'h07);
		send_word(dtr_pkg::CMD_READ, dtr_pkg::AddrTac, 8'h00);
		send_word(dtr_pkg::CMD_READ, dtr_pkg::AddrTima, 8'h00);
		directed_count = word_count;
		drain_answers();

		while (word_count < directed_count + RandomWords) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) < 7) begin
				overflow_run();
			end else begin
				noise_run();
			end
			if ($urandom_range(0, 5) == 0) begin
				drain_answers();
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (answers_owed != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("sent %0d timer words (%0d directed) and %0d out-of-map or unused ones",
			word_count, directed_count, ignored_count);
		$display("checked %0d result words with %0d interrupt requests and %0d bad addresses",
			answers_checked, irq_seen, bad_seen);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/dtr_pkg.sv
hdl/dtr_step.sv
hdl/divider_timer_with_delayed_reload_core.sv
dv/dtr_timer_checker.sv
dv/tb_divider_timer_with_delayed_reload_core.sv
